// File: rtl/core/line_pixel_rasterizer_assert.svh
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpr assertion failed");

// next-cycle implication, checked outside reset
`define LPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpr assertion failed");

`endif

// File: rtl/core/lpr_pkg.sv
package lpr_pkg;

    localparam int COORD_W = 11;
    localparam int ERR_W   = COORD_W + 1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ERR_W-1:0]   err_t;

    localparam coord_t COORD_MAX = coord_t'(2000);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_ADV  = 1'b1
    } action_t;

    typedef struct packed {
        action_t    action;
        coord_t     x_start;
        coord_t     y_start;
        coord_t     x_end;
        coord_t     y_end;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } cmd_t;

    typedef struct packed {
        coord_t     pixel_x;
        coord_t     pixel_y;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_pixel;
    } pix_t;

    typedef struct packed {
        logic   active;
        coord_t steps_left;
    } lpr_status_t;

endpackage

// File: rtl/core/line_pixel_rasterizer.sv
// channel   direction   handshake              payload
// cmd       into block  cmd_valid / cmd_ready  cmd_t  (load or advance request)
// pix       out of block pix_valid / pix_ready pix_t  (one pixel, color, last flag)
//
// one request per clock unless the pixel side stalls; pixels leave the pixel register
// the line state and one step of error update sit between the request and pixel registers
// reset clears the line state and both stage valids; nothing is emitted until a load
// a held pixel keeps pix_valid; the request stage then fills and cmd_ready drops
// an advance with no line in progress is consumed without a pixel

`include "line_pixel_rasterizer_assert.svh"

module line_pixel_rasterizer
    import lpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    logic        s1_valid;
    cmd_t        s1_cmd;
    logic        s1_take;
    logic        out_free;
    logic        res_valid;
    pix_t        res;
    lpr_status_t status;

    lpr_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .s1_valid  (s1_valid),
        .s1_cmd    (s1_cmd),
        .s1_take   (s1_take)
    );

    lpr_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_cmd    (s1_cmd),
        .s1_take   (s1_take),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    lpr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    `LPR_ASSERT_NOW(a_active_has_steps, status.active, status.steps_left != '0)
    `LPR_ASSERT_NOW(a_pix_in_range, pix_valid,
        (pix.pixel_x <= COORD_MAX) && (pix.pixel_y <= COORD_MAX))
    `LPR_ASSERT_NEXT(a_last_ends_line, res_valid && res.last_pixel, !status.active)
    `LPR_ASSERT_NOW(a_ready_when_empty, !s1_valid, cmd_ready)

endmodule

// File: rtl/core/lpr_in_stage.sv
module lpr_in_stage
    import lpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic s1_valid,
    output cmd_t s1_cmd,
    input  logic s1_take
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    function automatic coord_t clamp_coord(input coord_t v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    assign cmd_ready = !valid_reg || s1_take;

    always_comb
    begin
        cmd_next         = cmd;
        cmd_next.x_start = clamp_coord(cmd.x_start);
        cmd_next.y_start = clamp_coord(cmd.y_start);
        cmd_next.x_end   = clamp_coord(cmd.x_end);
        cmd_next.y_end   = clamp_coord(cmd.y_end);
        valid_next       = (cmd_valid && cmd_ready) ? 1'b1 :
                           (s1_take ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_cmd   = cmd_reg;

endmodule

// File: rtl/core/lpr_step.sv
module lpr_step
    import lpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s1_valid,
    input  cmd_t        s1_cmd,
    output logic        s1_take,
    input  logic        out_free,
    output logic        res_valid,
    output pix_t        res,
    output lpr_status_t status
);

    logic        active_reg,    active_next;
    coord_t      cur_x_reg,     cur_x_next;
    coord_t      cur_y_reg,     cur_y_next;
    err_t        error_acc_reg, error_acc_next;
    coord_t      steps_left_reg, steps_left_next;
    coord_t      major_len_reg, major_len_next;
    coord_t      minor_len_reg, minor_len_next;
    logic        x_major_reg,   x_major_next;
    logic        x_dir_neg_reg, x_dir_neg_next;
    logic        y_dir_neg_reg, y_dir_neg_next;
    logic [31:0] colour_reg,    colour_next;

    logic   is_load;
    logic   x_gt;
    logic   y_gt;
    coord_t adx;
    coord_t ady;
    logic   ld_x_major;
    coord_t ld_major;
    coord_t ld_minor;
    err_t   err_sum;
    err_t   major_ext;
    logic   minor_step;

    function automatic coord_t step_coord(input coord_t v, input logic neg);
        return neg ? (v - coord_t'(1)) : (v + coord_t'(1));
    endfunction

    assign s1_take = s1_valid && out_free;
    assign is_load = (s1_cmd.action == ACT_LOAD);

    // load path
    always_comb
    begin
        x_gt       = s1_cmd.x_end > s1_cmd.x_start;
        y_gt       = s1_cmd.y_end > s1_cmd.y_start;
        adx        = x_gt ? (s1_cmd.x_end - s1_cmd.x_start) : (s1_cmd.x_start - s1_cmd.x_end);
        ady        = y_gt ? (s1_cmd.y_end - s1_cmd.y_start) : (s1_cmd.y_start - s1_cmd.y_end);
        ld_x_major = adx > ady;
        ld_major   = ld_x_major ? adx : ady;
        ld_minor   = ld_x_major ? ady : adx;
    end

    // advance path
    always_comb
    begin
        major_ext  = {1'b0, major_len_reg};
        err_sum    = error_acc_reg + {1'b0, minor_len_reg};
        minor_step = x_major_reg ? (err_sum >= major_ext) : (err_sum > major_ext);
    end

    always_comb
    begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        error_acc_next  = error_acc_reg;
        steps_left_next = steps_left_reg;
        major_len_next  = major_len_reg;
        minor_len_next  = minor_len_reg;
        x_major_next    = x_major_reg;
        x_dir_neg_next  = x_dir_neg_reg;
        y_dir_neg_next  = y_dir_neg_reg;
        colour_next     = colour_reg;
        if (is_load)
        begin
            x_dir_neg_next  = !x_gt;
            y_dir_neg_next  = !y_gt;
            x_major_next    = ld_x_major;
            major_len_next  = ld_major;
            minor_len_next  = ld_minor;
            error_acc_next  = {1'b0, ld_major} >> 1;
            steps_left_next = ld_major;
            cur_x_next      = s1_cmd.x_start;
            cur_y_next      = s1_cmd.y_start;
            colour_next     = {s1_cmd.red_in, s1_cmd.green_in,
                               s1_cmd.blue_in, s1_cmd.alpha_in};
            active_next     = (ld_major != '0);
        end
        else if (active_reg)
        begin
            error_acc_next  = minor_step ? (err_sum - major_ext) : err_sum;
            if (x_major_reg || minor_step)
            begin
                cur_x_next = step_coord(cur_x_reg, x_dir_neg_reg);
            end
            if (!x_major_reg || minor_step)
            begin
                cur_y_next = step_coord(cur_y_reg, y_dir_neg_reg);
            end
            steps_left_next = steps_left_reg - coord_t'(1);
            active_next     = (steps_left_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            error_acc_reg  <= '0;
            steps_left_reg <= '0;
            major_len_reg  <= '0;
            minor_len_reg  <= '0;
            x_major_reg    <= 1'b0;
            x_dir_neg_reg  <= 1'b0;
            y_dir_neg_reg  <= 1'b0;
            colour_reg     <= '0;
        end
        else if (s1_take)
        begin
            active_reg     <= active_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            error_acc_reg  <= error_acc_next;
            steps_left_reg <= steps_left_next;
            major_len_reg  <= major_len_next;
            minor_len_reg  <= minor_len_next;
            x_major_reg    <= x_major_next;
            x_dir_neg_reg  <= x_dir_neg_next;
            y_dir_neg_reg  <= y_dir_neg_next;
            colour_reg     <= colour_next;
        end
    end

    always_comb
    begin
        res_valid      = s1_take && (is_load || active_reg);
        res.pixel_x    = cur_x_next;
        res.pixel_y    = cur_y_next;
        res.red_out    = colour_next[31:24];
        res.green_out  = colour_next[23:16];
        res.blue_out   = colour_next[15:8];
        res.alpha_out  = colour_next[7:0];
        res.last_pixel = !active_next;
    end

    assign status.active     = active_reg;
    assign status.steps_left = steps_left_reg;

endmodule

// File: rtl/core/lpr_out_stage.sv
module lpr_out_stage
    import lpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  pix_t res,
    output logic out_free,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    logic valid_reg;
    logic valid_next;
    pix_t pix_reg;

    assign out_free   = !valid_reg || pix_ready;
    assign valid_next = out_free ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            pix_reg <= res;
        end
    end

    assign pix_valid = valid_reg;
    assign pix       = pix_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import lpr_pkg::*;

    localparam int STALL_MAX   = 8;
    localparam int IDLE_LIMIT  = 1000;
    localparam int ITEM_TARGET = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic pix_valid;
    logic pix_ready = 1'b0;
    pix_t pix;

    line_pixel_rasterizer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix(pix)
    );

    always #5 clk = ~clk;

    // line state mirrored from the block
    logic        line_active = 1'b0;
    coord_t      pos_x = '0;
    coord_t      pos_y = '0;
    err_t        err_acc = '0;
    coord_t      steps_rem = '0;
    coord_t      major_len = '0;
    coord_t      minor_len = '0;
    logic        x_major = 1'b0;
    logic        x_neg = 1'b0;
    logic        y_neg = 1'b0;
    logic [31:0] line_colour = '0;

    cmd_t pending_requests[$];
    pix_t expected_pixels[$];

    logic cmd_taken = 1'b0;
    logic pix_taken = 1'b0;
    logic cmd_burst = 1'b0;
    logic pix_burst = 1'b0;
    int   cmd_gap = 0;
    int   pix_stall = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;

    function automatic coord_t clamp_coord(coord_t v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic logic rasterize_step(input cmd_t c, output pix_t p);
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
        coord_t adx;
        coord_t ady;
        p = '0;
        if (c.action == ACT_LOAD)
        begin
            xs = clamp_coord(c.x_start);
            ys = clamp_coord(c.y_start);
            xe = clamp_coord(c.x_end);
            ye = clamp_coord(c.y_end);
            x_neg = !(xe > xs);
            y_neg = !(ye > ys);
            adx = (xe > xs) ? xe - xs : xs - xe;
            ady = (ye > ys) ? ye - ys : ys - ye;
            x_major = adx > ady;
            major_len = x_major ? adx : ady;
            minor_len = x_major ? ady : adx;
            err_acc = err_t'(major_len >> 1);
            steps_rem = major_len;
            pos_x = xs;
            pos_y = ys;
            line_colour = {c.red_in, c.green_in, c.blue_in, c.alpha_in};
        end
        else if (!line_active)
        begin
            return 1'b0;
        end
        else
        begin
            err_acc = err_acc + err_t'(minor_len);
            if (x_major)
            begin
                pos_x = x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
                if (err_acc >= err_t'(major_len))
                begin
                    err_acc = err_acc - err_t'(major_len);
                    pos_y = y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
                end
            end
            else
            begin
                pos_y = y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
                if (err_acc > err_t'(major_len))
                begin
                    err_acc = err_acc - err_t'(major_len);
                    pos_x = x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
                end
            end
            steps_rem = steps_rem - 1'b1;
        end
        line_active = steps_rem != '0;
        p.pixel_x = pos_x;
        p.pixel_y = pos_y;
        {p.red_out, p.green_out, p.blue_out, p.alpha_out} = line_colour;
        p.last_pixel = !line_active;
        return 1'b1;
    endfunction

    task automatic add_load(input coord_t xs, input coord_t ys, input coord_t xe,
                            input coord_t ye);
        cmd_t c;
        c.action = ACT_LOAD;
        c.x_start = xs;
        c.y_start = ys;
        c.x_end = xe;
        c.y_end = ye;
        c.red_in = 8'($urandom);
        c.green_in = 8'($urandom);
        c.blue_in = 8'($urandom);
        c.alpha_in = 8'($urandom);
        pending_requests.push_back(c);
    endtask

    task automatic add_advances(input int n);
        cmd_t c;
        for (int i = 0; i < n; i++)
        begin
            c.action = ACT_ADV;
            c.x_start = coord_t'($urandom);
            c.y_start = coord_t'($urandom);
            c.x_end = coord_t'($urandom);
            c.y_end = coord_t'($urandom);
            c.red_in = 8'($urandom);
            c.green_in = 8'($urandom);
            c.blue_in = 8'($urandom);
            c.alpha_in = 8'($urandom);
            pending_requests.push_back(c);
        end
    endtask

    function automatic coord_t offset_coord(coord_t base, int span);
        int e;
        e = int'(clamp_coord(base)) + int'($urandom_range(0, 2 * span)) - span;
        if (e < 0)
            e = 0;
        if (e > 2047)
            e = 2047;
        return coord_t'(e);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_taken))
        begin
            if (cmd_gap != 0)
            begin
                cmd_valid <= 1'b0;
                cmd_gap <= cmd_gap - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                cmd <= pending_requests.pop_front();
                cmd_valid <= 1'b1;
                cmd_gap <= cmd_burst ? 0 : int'($urandom_range(0, STALL_MAX));
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // pixel sink
    always @(negedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            if (pix_taken)
                stall = pix_burst ? 0 : int'($urandom_range(0, STALL_MAX));
            else
                stall = pix_stall;
            if (stall != 0)
            begin
                pix_ready <= 1'b0;
                pix_stall <= stall - 1;
            end
            else
            begin
                pix_ready <= 1'b1;
                pix_stall <= 0;
            end
        end
    end

    // checker and request tracking
    always @(posedge clk)
    begin
        pix_t want;
        pix_t next_pix;
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t unexpected pixel: x=%0d y=%0d rgba=%h last=%0b", $time,
                             pix.pixel_x, pix.pixel_y,
                             {pix.red_out, pix.green_out, pix.blue_out, pix.alpha_out},
                             pix.last_pixel);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix.pixel_x !== want.pixel_x || pix.pixel_y !== want.pixel_y
                        || pix.red_out !== want.red_out || pix.green_out !== want.green_out
                        || pix.blue_out !== want.blue_out || pix.alpha_out !== want.alpha_out
                        || pix.last_pixel !== want.last_pixel)
                    begin
                        $display("%0t pixel mismatch: expected x=%0d y=%0d rgba=%h last=%0b",
                                 $time, want.pixel_x, want.pixel_y,
                                 {want.red_out, want.green_out, want.blue_out, want.alpha_out},
                                 want.last_pixel);
                        $display("%0t                   actual x=%0d y=%0d rgba=%h last=%0b",
                                 $time, pix.pixel_x, pix.pixel_y,
                                 {pix.red_out, pix.green_out, pix.blue_out, pix.alpha_out},
                                 pix.last_pixel);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                if (rasterize_step(cmd, next_pix))
                    expected_pixels.push_back(next_pix);
            end
            cmd_taken <= cmd_valid && cmd_ready;
            pix_taken <= pix_valid && pix_ready;
            if ($urandom_range(0, 99) == 0)
                cmd_burst <= !cmd_burst;
            if ($urandom_range(0, 99) == 0)
                pix_burst <= !pix_burst;
            if ((cmd_valid && cmd_ready) || (pix_valid && pix_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL line_pixel_rasterizer");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int     kind;
        int     span;
        int     major;
        int     dx;
        int     dy;
        int     n;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;

        // advance with no line yet
        add_advances(1);
        // clamped degenerate line, then advance after the last pixel
        add_load(11'd2047, 11'd2047, 11'd2047, 11'd2047);
        add_advances(1);
        add_load(11'd0, 11'd0, 11'd4, 11'd1);
        add_advances(4);
        add_load(11'd2047, 11'd0, 11'd1997, 11'd1);
        add_advances(3);
        // diagonal tie runs y-major
        add_load(11'd5, 11'd5, 11'd2, 11'd2);
        add_advances(3);
        // abandoned by the next load
        add_load(11'd0, 11'd2047, 11'd1, 11'd1996);
        add_advances(1);
        add_load(11'd7, 11'd0, 11'd7, 11'd3);
        add_advances(3);
        add_load(11'd0, 11'd9, 11'd2, 11'd9);
        add_advances(3);

        while (pending_requests.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 5)
            begin
                add_advances(1);
            end
            else
            begin
                xs = coord_t'($urandom);
                ys = coord_t'($urandom);
                if (kind < 10)
                begin
                    xe = coord_t'($urandom);
                    ye = coord_t'($urandom);
                end
                else
                begin
                    span = (kind < 75) ? 8 : 64;
                    xe = offset_coord(xs, span);
                    ye = offset_coord(ys, span);
                end
                dx = int'(clamp_coord(xe)) - int'(clamp_coord(xs));
                dy = int'(clamp_coord(ye)) - int'(clamp_coord(ys));
                dx = (dx < 0) ? -dx : dx;
                dy = (dy < 0) ? -dy : dy;
                major = (dx > dy) ? dx : dy;
                n = $urandom_range(0, 9);
                if (n < 8)
                    n = major;
                else if (n == 8)
                    n = major + int'($urandom_range(1, 3));
                else
                    n = (major == 0) ? 0 : int'($urandom_range(0, major - 1));
                if (kind < 10 && n > 40)
                    n = $urandom_range(0, 40);
                add_load(xs, ys, xe, ye);
                add_advances(n);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("PASS line_pixel_rasterizer");
        else
            $display("FAIL line_pixel_rasterizer");
        $finish;
    end

endmodule
